### rtl/core/rftd_pkg.sv
// ----------------------------------------------------------------------------
// rftd_pkg
// Shared types and constants of the frame deframer.
// ----------------------------------------------------------------------------
package rftd_pkg;

    localparam int HDR_BYTES  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_METH_TAG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TAG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_TAG  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_META  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY  = 3'd6;

    typedef enum logic [1:0] {
        KIND_METHOD = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_END    = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_MAGIC   = 2'd0,
        CAUSE_VERSION = 2'd1,
        CAUSE_LENGTH  = 2'd2,
        CAUSE_NONE    = 2'd3
    } t_cause;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_META = 2'd1,
        PH_SKIP = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef struct packed {
        logic [15:0] magic;
        logic [7:0]  version;
        logic [7:0]  meth_tag;
        logic [7:0]  dead_tag;
        logic [7:0]  task_tag;
        logic [31:0] max_meta;
        logic [31:0] max_body;
    } t_cfg;

    // classified result, front to back
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        eof;
        logic [1:0]  cause;
        logic [7:0]  flags;
        logic [7:0]  mtype;
        logic [7:0]  status;
        logic [63:0] req;
        logic [63:0] deadline;
        logic [63:0] task_id;
        logic [15:0] meth_len;
        logic [31:0] body_len;
    } t_res;

endpackage

### rtl/core/rftd_front.sv
// ----------------------------------------------------------------------------
// rftd_front
// Header capture, checks and TLV classification; one byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module rftd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rftd_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_ready,
    output logic              o_res_valid,
    output rftd_pkg::t_res    o_res,
    input  logic              i_q_ready
);
    import rftd_pkg::*;

    t_phase r_phase, n_phase;
    logic        r_halted, n_halted;
    logic [4:0]  r_hidx, n_hidx;
    logic [15:0] r_magic, n_magic;
    logic [7:0]  r_ver, n_ver, r_flags, n_flags, r_type, n_type, r_stat, n_stat;
    logic [63:0] r_req, n_req;
    logic [31:0] r_mtot, n_mtot, r_btot, n_btot, r_mcon, n_mcon, r_brem, n_brem;
    logic [1:0]  r_step, n_step;
    logic [7:0]  r_ttype, n_ttype;
    logic [15:0] r_tlen, n_tlen, r_vidx, n_vidx, r_mlen, n_mlen;
    logic [63:0] r_shift, n_shift, r_dead, n_dead, r_task, n_task;
    logic        fire;
    logic [15:0] len_full;
    logic [15:0] vidx_inc;
    logic [32:0] end_pos;
    logic [31:0] mcon_inc;
    logic        meth_byte;

    assign o_ready = i_q_ready;
    assign fire    = i_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD; r_halted <= 1'b0; r_hidx <= '0;
            r_magic <= '0; r_ver <= '0; r_flags <= '0; r_type <= '0; r_stat <= '0;
            r_req <= '0; r_mtot <= '0; r_btot <= '0; r_mcon <= '0; r_brem <= '0;
            r_step <= '0; r_ttype <= '0; r_tlen <= '0; r_vidx <= '0; r_mlen <= '0;
            r_shift <= '0; r_dead <= '0; r_task <= '0;
        end else begin
            r_phase <= n_phase; r_halted <= n_halted; r_hidx <= n_hidx;
            r_magic <= n_magic; r_ver <= n_ver; r_flags <= n_flags;
            r_type <= n_type; r_stat <= n_stat; r_req <= n_req;
            r_mtot <= n_mtot; r_btot <= n_btot; r_mcon <= n_mcon; r_brem <= n_brem;
            r_step <= n_step; r_ttype <= n_ttype; r_tlen <= n_tlen;
            r_vidx <= n_vidx; r_mlen <= n_mlen; r_shift <= n_shift;
            r_dead <= n_dead; r_task <= n_task;
        end
    end

    always_comb begin
        n_phase = r_phase; n_halted = r_halted; n_hidx = r_hidx;
        n_magic = r_magic; n_ver = r_ver; n_flags = r_flags; n_type = r_type;
        n_stat = r_stat; n_req = r_req; n_mtot = r_mtot; n_btot = r_btot;
        n_mcon = r_mcon; n_brem = r_brem; n_step = r_step; n_ttype = r_ttype;
        n_tlen = r_tlen; n_vidx = r_vidx; n_mlen = r_mlen; n_shift = r_shift;
        n_dead = r_dead; n_task = r_task;
        o_res_valid = 1'b0;
        o_res = '0;
        meth_byte = 1'b0;
        len_full = {r_tlen[7:0], i_byte};
        vidx_inc = r_vidx + 16'd1;
        end_pos = {1'b0, r_mcon} + 33'd1 + {17'd0, len_full};
        mcon_inc = r_mcon + 32'd1;

        if (fire && !r_halted) begin
            case (r_phase)
                PH_HEAD: begin
                    if (r_hidx < 5'd2) n_magic = {r_magic[7:0], i_byte};
                    else if (r_hidx == 5'd2) n_ver = i_byte;
                    else if (r_hidx == 5'd3) n_flags = i_byte;
                    else if (r_hidx == 5'd4) n_type = i_byte;
                    else if (r_hidx == 5'd5) n_stat = i_byte;
                    else if (r_hidx >= 5'd8 && r_hidx < 5'd16) n_req = {r_req[55:0], i_byte};
                    else if (r_hidx >= 5'd16 && r_hidx < 5'd20)
                        n_mtot = {r_mtot[23:0], i_byte};
                    else if (r_hidx >= 5'd20) n_btot = {r_btot[23:0], i_byte};
                    n_hidx = r_hidx + 5'd1;
                    if (r_hidx == 5'(HDR_BYTES - 1)) begin
                        n_hidx = '0;
                        o_res.kind = KIND_ERROR;
                        if (r_magic != i_cfg.magic) begin
                            n_halted = 1'b1; o_res_valid = 1'b1; o_res.cause = CAUSE_MAGIC;
                        end else if (r_ver != i_cfg.version) begin
                            n_halted = 1'b1; o_res_valid = 1'b1;
                            o_res.cause = CAUSE_VERSION;
                        end else if (r_mtot > i_cfg.max_meta || n_btot > i_cfg.max_body) begin
                            n_halted = 1'b1; o_res_valid = 1'b1;
                            o_res.cause = CAUSE_LENGTH;
                        end else begin
                            n_dead = '0; n_task = '0; n_mlen = '0; n_mcon = '0;
                            n_step = '0; n_shift = '0; n_brem = n_btot;
                            if (r_mtot != 32'd0) n_phase = PH_META;
                            else if (n_btot != 32'd0) n_phase = PH_BODY;
                            else begin
                                o_res_valid = 1'b1;
                                o_res = '0;
                                o_res.kind = KIND_END;
                                o_res.eof = 1'b1;
                                o_res.flags = r_flags; o_res.mtype = r_type;
                                o_res.status = r_stat; o_res.req = r_req;
                                o_res.body_len = n_btot;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    n_brem = r_brem - 32'd1;
                    o_res_valid = 1'b1;
                    o_res.kind = KIND_BODY;
                    o_res.data = i_byte;
                    if (n_brem == 32'd0) begin
                        o_res.eof = 1'b1;
                        o_res.flags = r_flags; o_res.mtype = r_type;
                        o_res.status = r_stat; o_res.req = r_req;
                        o_res.deadline = r_dead; o_res.task_id = r_task;
                        o_res.meth_len = r_mlen; o_res.body_len = r_btot;
                        n_phase = PH_HEAD; n_step = '0;
                    end
                end
                default: begin
                    if (r_phase == PH_META) begin
                        case (r_step)
                            2'd0: begin
                                if ((r_mtot - r_mcon) < 32'd3) n_phase = PH_SKIP;
                                else begin
                                    n_ttype = i_byte; n_step = 2'd1;
                                end
                            end
                            2'd1: begin
                                n_tlen = {8'd0, i_byte}; n_step = 2'd2;
                            end
                            2'd2: begin
                                n_tlen = len_full;
                                if (end_pos > {1'b0, r_mtot}) n_phase = PH_SKIP;
                                else begin
                                    if (r_ttype == i_cfg.meth_tag) n_mlen = len_full;
                                    n_vidx = '0; n_shift = '0;
                                    n_step = (len_full == 16'd0) ? 2'd0 : 2'd3;
                                end
                            end
                            default: begin
                                if (r_ttype == i_cfg.meth_tag) meth_byte = 1'b1;
                                else n_shift = {r_shift[55:0], i_byte};
                                n_vidx = vidx_inc;
                                if (vidx_inc == r_tlen) begin
                                    if (r_ttype != i_cfg.meth_tag && r_tlen == 16'd8) begin
                                        if (r_ttype == i_cfg.dead_tag) n_dead = n_shift;
                                        else if (r_ttype == i_cfg.task_tag)
                                            n_task = n_shift;
                                    end
                                    n_step = '0;
                                end
                            end
                        endcase
                    end
                    n_mcon = mcon_inc;
                    if (meth_byte) begin
                        o_res_valid = 1'b1; o_res.kind = KIND_METHOD; o_res.data = i_byte;
                    end
                    if (mcon_inc >= r_mtot) begin
                        n_step = '0;
                        if (r_btot != 32'd0) n_phase = PH_BODY;
                        else begin
                            o_res_valid = 1'b1;
                            o_res.kind = meth_byte ? KIND_METHOD : KIND_END;
                            o_res.data = meth_byte ? i_byte : 8'd0;
                            o_res.eof = 1'b1;
                            o_res.flags = r_flags; o_res.mtype = r_type;
                            o_res.status = r_stat; o_res.req = r_req;
                            o_res.deadline = n_dead; o_res.task_id = n_task;
                            o_res.meth_len = n_mlen; o_res.body_len = r_btot;
                            n_phase = PH_HEAD;
                        end
                    end
                end
            endcase
        end
        if (o_res.kind != KIND_ERROR) o_res.cause = 2'd0;
    end

endmodule

### rtl/core/rftd_queue.sv
// ----------------------------------------------------------------------------
// rftd_queue
// Short result queue between classifier and output stage.
// ----------------------------------------------------------------------------
module rftd_queue #(
    parameter int DEPTH = rftd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  rftd_pkg::t_res    i_data,
    output logic              o_not_full,
    output logic              o_valid,
    output rftd_pkg::t_res    o_data,
    input  logic              i_rd
);
    import rftd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_res r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_wr, do_rd;

    assign o_not_full = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];
    assign do_wr      = i_wr && o_not_full;
    assign do_rd      = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_wr) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (do_rd) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end

endmodule

### rtl/core/rftd_back.sv
// ----------------------------------------------------------------------------
// rftd_back
// Output register stage driving the result channel.
// ----------------------------------------------------------------------------
module rftd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rftd_pkg::t_res    i_data,
    output logic              o_take,
    output logic              o_valid,
    output rftd_pkg::t_res    o_data,
    input  logic              i_ready
);
    import rftd_pkg::*;

    logic r_valid;
    t_res r_data;

    assign o_take  = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_data <= i_data;
    end

endmodule

### rtl/core/rpc_frame_tlv_deframer.sv
// ----------------------------------------------------------------------------
// rpc_frame_tlv_deframer
// Deframer for length-prefixed frames with TLV metadata.
// Path: each result is written into the result queue and then into the output
// register, from which it is presented.
// Throughput: 1 byte per cycle while the result queue has room.
// Reset: synchronous active low; clears parser state, queue pointers, output
// valid and configuration to 0.
// ----------------------------------------------------------------------------
module rpc_frame_tlv_deframer #(
    parameter int QUEUE_DEPTH = rftd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [rftd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rftd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_end_of_frame,
    output logic [1:0]  o_error_cause,
    output logic [7:0]  o_frame_flags,
    output logic [7:0]  o_message_type,
    output logic [7:0]  o_status_code,
    output logic [63:0] o_request_id,
    output logic [63:0] o_deadline_ms,
    output logic [63:0] o_task_id,
    output logic [15:0] o_method_length,
    output logic [31:0] o_body_length
);
    import rftd_pkg::*;

    t_cfg r_cfg;
    t_res f_res, q_res, b_res;
    logic f_valid, q_nf, q_valid, q_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC:    r_cfg.magic    <= i_cfg_data[15:0];
                CFG_VERSION:  r_cfg.version  <= i_cfg_data[7:0];
                CFG_METH_TAG: r_cfg.meth_tag <= i_cfg_data[7:0];
                CFG_DEAD_TAG: r_cfg.dead_tag <= i_cfg_data[7:0];
                CFG_TASK_TAG: r_cfg.task_tag <= i_cfg_data[7:0];
                CFG_MAX_META: r_cfg.max_meta <= i_cfg_data;
                CFG_MAX_BODY: r_cfg.max_body <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rftd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_valid), .i_byte(i_in_byte), .o_ready(o_ready),
        .o_res_valid(f_valid), .o_res(f_res), .i_q_ready(q_nf)
    );

    rftd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(f_valid), .i_data(f_res),
        .o_not_full(q_nf), .o_valid(q_valid), .o_data(q_res), .i_rd(q_take)
    );

    rftd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_data(q_res),
        .o_take(q_take), .o_valid(o_valid), .o_data(b_res), .i_ready(i_ready)
    );

    assign o_kind          = b_res.kind;
    assign o_data_byte     = b_res.data;
    assign o_end_of_frame  = b_res.eof;
    assign o_error_cause   = b_res.cause;
    assign o_frame_flags   = b_res.flags;
    assign o_message_type  = b_res.mtype;
    assign o_status_code   = b_res.status;
    assign o_request_id    = b_res.req;
    assign o_deadline_ms   = b_res.deadline;
    assign o_task_id       = b_res.task_id;
    assign o_method_length = b_res.meth_len;
    assign o_body_length   = b_res.body_len;

endmodule

### verif/rpc_frame_tlv_deframer_tb.sv
// ----------------------------------------------------------------------------
// rpc_frame_tlv_deframer_tb
// Self-checking bench for the frame deframer. Builds frames with random
// headers, TLV metadata (method, deadline, task, unknown, short tails and
// overrunning entries) and bodies, streams them under random idling and
// back-pressure, and checks every result against an in-bench predictor.
// The run ends with one bad header, after which the block must stay silent.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rpc_frame_tlv_deframer_tb;
    import rftd_pkg::*;

    class frame_scoreboard;
        t_cfg        cfg;
        t_phase      phase;
        bit          halted;
        int unsigned hdr_idx;
        logic [15:0] magic_seen;
        logic [7:0]  version_seen, flags_h, type_h, status_h;
        logic [63:0] req_h;
        logic [31:0] meta_total, body_total, meta_used, body_left;
        int unsigned tlv_step;
        logic [7:0]  tlv_type;
        logic [15:0] tlv_len, tlv_pos;
        logic [63:0] shift_val, deadline_h, task_h;
        logic [15:0] meth_len_h;
        t_res        expected_q[$];
        int          errors;

        function new();
            cfg = '0;
            phase = PH_HEAD;
            halted = 0;
            hdr_idx = 0;
            magic_seen = 0; version_seen = 0; flags_h = 0; type_h = 0; status_h = 0;
            req_h = 0; meta_total = 0; body_total = 0; meta_used = 0; body_left = 0;
            tlv_step = 0; tlv_type = 0; tlv_len = 0; tlv_pos = 0;
            shift_val = 0; deadline_h = 0; task_h = 0; meth_len_h = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_MAGIC:    cfg.magic    = d[15:0];
                CFG_VERSION:  cfg.version  = d[7:0];
                CFG_METH_TAG: cfg.meth_tag = d[7:0];
                CFG_DEAD_TAG: cfg.dead_tag = d[7:0];
                CFG_TASK_TAG: cfg.task_tag = d[7:0];
                CFG_MAX_META: cfg.max_meta = d;
                CFG_MAX_BODY: cfg.max_body = d;
                default: ;
            endcase
        endfunction

        function void push_result(t_kind k, logic [7:0] d, bit eof, t_cause c);
            t_res r;
            r = '0;
            r.kind = k;
            r.data = d;
            r.cause = (k == KIND_ERROR) ? c : 2'd0;
            if (eof) begin
                r.eof = 1;
                r.flags = flags_h;
                r.mtype = type_h;
                r.status = status_h;
                r.req = req_h;
                r.deadline = deadline_h;
                r.task_id = task_h;
                r.meth_len = meth_len_h;
                r.body_len = body_total;
            end
            expected_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            bit meth_byte;
            meth_byte = 0;
            if (halted) return;
            if (phase == PH_HEAD) begin
                if (hdr_idx < 2) magic_seen = {magic_seen[7:0], b};
                else if (hdr_idx == 2) version_seen = b;
                else if (hdr_idx == 3) flags_h = b;
                else if (hdr_idx == 4) type_h = b;
                else if (hdr_idx == 5) status_h = b;
                else if (hdr_idx >= 8 && hdr_idx < 16) req_h = {req_h[55:0], b};
                else if (hdr_idx >= 16 && hdr_idx < 20) meta_total = {meta_total[23:0], b};
                else if (hdr_idx >= 20) body_total = {body_total[23:0], b};
                if (hdr_idx < HDR_BYTES - 1) begin
                    hdr_idx++;
                    return;
                end
                hdr_idx = 0;
                if (magic_seen != cfg.magic) begin
                    halted = 1; push_result(KIND_ERROR, 0, 0, CAUSE_MAGIC); return;
                end
                if (version_seen != cfg.version) begin
                    halted = 1; push_result(KIND_ERROR, 0, 0, CAUSE_VERSION); return;
                end
                if (meta_total > cfg.max_meta || body_total > cfg.max_body) begin
                    halted = 1; push_result(KIND_ERROR, 0, 0, CAUSE_LENGTH); return;
                end
                deadline_h = 0; task_h = 0; meth_len_h = 0;
                meta_used = 0; tlv_step = 0; shift_val = 0;
                body_left = body_total;
                if (meta_total != 0) phase = PH_META;
                else if (body_total != 0) phase = PH_BODY;
                else begin
                    push_result(KIND_END, 0, 1, CAUSE_MAGIC);
                    phase = PH_HEAD;
                end
                return;
            end
            if (phase == PH_BODY) begin
                body_left--;
                if (body_left == 0) begin
                    push_result(KIND_BODY, b, 1, CAUSE_MAGIC);
                    phase = PH_HEAD;
                    hdr_idx = 0;
                    tlv_step = 0;
                end else begin
                    push_result(KIND_BODY, b, 0, CAUSE_MAGIC);
                end
                return;
            end
            if (phase == PH_META) begin
                if (tlv_step == 0) begin
                    if (meta_total - meta_used < 3) phase = PH_SKIP;
                    else begin
                        tlv_type = b;
                        tlv_step = 1;
                    end
                end else if (tlv_step == 1) begin
                    tlv_len = {8'd0, b};
                    tlv_step = 2;
                end else if (tlv_step == 2) begin
                    tlv_len = {tlv_len[7:0], b};
                    if (64'(meta_used) + 1 + 64'(tlv_len) > 64'(meta_total)) begin
                        phase = PH_SKIP;
                    end else begin
                        if (tlv_type == cfg.meth_tag) meth_len_h = tlv_len;
                        tlv_pos = 0;
                        shift_val = 0;
                        tlv_step = (tlv_len == 0) ? 0 : 3;
                    end
                end else begin
                    if (tlv_type == cfg.meth_tag) meth_byte = 1;
                    else shift_val = {shift_val[55:0], b};
                    tlv_pos++;
                    if (tlv_pos == tlv_len) begin
                        if (tlv_type != cfg.meth_tag && tlv_len == 8) begin
                            if (tlv_type == cfg.dead_tag) deadline_h = shift_val;
                            else if (tlv_type == cfg.task_tag) task_h = shift_val;
                        end
                        tlv_step = 0;
                    end
                end
            end
            meta_used++;
            if (meta_used >= meta_total) begin
                tlv_step = 0;
                if (body_total != 0) phase = PH_BODY;
                else begin
                    if (meth_byte) push_result(KIND_METHOD, b, 1, CAUSE_MAGIC);
                    else push_result(KIND_END, 0, 1, CAUSE_MAGIC);
                    phase = PH_HEAD;
                    hdr_idx = 0;
                    return;
                end
            end
            if (meth_byte) push_result(KIND_METHOD, b, 0, CAUSE_MAGIC);
        endfunction

        function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
                         act_v);
            end
        endfunction

        function void check(t_res got);
            t_res e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, got.kind);
                return;
            end
            e = expected_q.pop_front();
            cmp_field("kind", e.kind, got.kind);
            cmp_field("data_byte", e.data, got.data);
            cmp_field("end_of_frame", e.eof, got.eof);
            cmp_field("error_cause", e.cause, got.cause);
            cmp_field("frame_flags", e.flags, got.flags);
            cmp_field("message_type", e.mtype, got.mtype);
            cmp_field("status_code", e.status, got.status);
            cmp_field("request_id", e.req, got.req);
            cmp_field("deadline_ms", e.deadline, got.deadline);
            cmp_field("task_id", e.task_id, got.task_id);
            cmp_field("method_length", e.meth_len, got.meth_len);
            cmp_field("body_length", e.body_len, got.body_len);
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [7:0]  i_in_byte = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic        o_end_of_frame;
    logic [1:0]  o_error_cause;
    logic [7:0]  o_frame_flags, o_message_type, o_status_code;
    logic [63:0] o_request_id, o_deadline_ms, o_task_id;
    logic [15:0] o_method_length;
    logic [31:0] o_body_length;

    frame_scoreboard sb = new();
    int          send_idle_pct = 37;
    int          recv_idle_pct = 37;
    int          hold_cycles = 0;
    int          bytes_sent = 0;
    int          cycle_cnt = 0;
    logic [7:0]  frame_bytes[$];

    rpc_frame_tlv_deframer dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("rpc_frame_tlv_deframer regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check({t_kind'(o_kind), o_data_byte, o_end_of_frame, o_error_cause,
                          o_frame_flags, o_message_type, o_status_code, o_request_id,
                          o_deadline_ms, o_task_id, o_method_length, o_body_length});
            end
            if (hold_cycles > 0) begin
                i_ready <= 0;
                hold_cycles--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_in_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic write_config(t_cfg c);
        logic [CFG_DATA_W-1:0] vals[7];
        vals = '{32'(c.magic), 32'(c.version), 32'(c.meth_tag), 32'(c.dead_tag),
                 32'(c.task_tag), c.max_meta, c.max_body};
        for (int k = 0; k < 7; k++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= CFG_IDX_W'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.write_reg(CFG_IDX_W'(k), vals[k]);
        end
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // build one frame into frame_bytes; the body length is clipped to its limit, metadata over its limit is dropped
    task automatic make_frame(int n_tlv, int tail_mode, int blen);
        logic [7:0]  meta[$];
        logic [63:0] req;
        logic [31:0] mlen, bl;
        int          sel, len;
        logic [7:0]  tag;
        meta = {};
        for (int t = 0; t < n_tlv; t++) begin
            sel = $urandom_range(3);
            case (sel)
                0: begin tag = sb.cfg.meth_tag; len = $urandom_range(5); end
                1: begin
                    tag = sb.cfg.dead_tag;
                    len = ($urandom_range(4) == 0) ? $urandom_range(9) : 8;
                end
                2: begin
                    tag = sb.cfg.task_tag;
                    len = ($urandom_range(4) == 0) ? $urandom_range(9) : 8;
                end
                default: begin tag = 8'($urandom); len = $urandom_range(4); end
            endcase
            meta.push_back(tag);
            meta.push_back(8'(len >> 8));
            meta.push_back(8'(len));
            repeat (len) meta.push_back(8'($urandom));
        end
        if (tail_mode == 1) begin
            repeat ($urandom_range(1, 2)) meta.push_back(8'($urandom));
        end else if (tail_mode == 2) begin
            len = $urandom_range(1, 6);
            meta.push_back(($urandom_range(1) == 0) ? sb.cfg.meth_tag : 8'($urandom));
            meta.push_back(8'($urandom_range(1) == 0 ? 8'hFF : 8'h00));
            meta.push_back(8'(len + 2));
            repeat (len) meta.push_back(8'($urandom));
        end
        if (meta.size() > sb.cfg.max_meta) meta = {};
        mlen = 32'(meta.size());
        bl = (blen > sb.cfg.max_body) ? sb.cfg.max_body : 32'(blen);
        req = {$urandom, $urandom};
        frame_bytes = {sb.cfg.magic[15:8], sb.cfg.magic[7:0], sb.cfg.version,
                       8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        for (int k = 7; k >= 0; k--) frame_bytes.push_back(req[k*8 +: 8]);
        for (int k = 3; k >= 0; k--) frame_bytes.push_back(mlen[k*8 +: 8]);
        for (int k = 3; k >= 0; k--) frame_bytes.push_back(bl[k*8 +: 8]);
        frame_bytes = {frame_bytes, meta};
        repeat (bl) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
    endtask

    task automatic random_frames(int n);
        repeat (n) begin
            make_frame($urandom_range(4), $urandom_range(2),
                       ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(8));
            send_frame();
        end
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.magic = 16'($urandom);
        c.version = 8'($urandom);
        c.meth_tag = 8'($urandom);
        c.dead_tag = ($urandom_range(5) == 0) ? c.meth_tag : 8'($urandom);
        c.task_tag = ($urandom_range(5) == 0) ? c.dead_tag : 8'($urandom);
        c.max_meta = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 60);
        c.max_body = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 40);
        return c;
    endfunction

    initial begin
        t_cfg c;
        int   cause;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        c = '{16'hA55A, 8'h01, 8'h01, 8'h02, 8'h03, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        write_config(c);
        make_frame(0, 0, 0); send_frame();
        make_frame(3, 0, 4); send_frame();
        make_frame(0, 1, 0); send_frame();
        make_frame(2, 2, 3); send_frame();
        make_frame(0, 0, 2); send_frame();
        random_frames(2);
        drain();

        c = '{16'h0000, 8'h00, 8'h07, 8'h07, 8'h07, 32'd64, 32'd32};
        write_config(c);
        random_frames(3);
        drain();

        c = '{16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 32'd0, 32'hFFFF_FFFF};
        write_config(c);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_frames(5);
        send_idle_pct = 37;
        recv_idle_pct = 37;
        drain();

        write_config(random_cfg());
        hold_cycles = 300;
        random_frames(4);
        drain();

        while (bytes_sent < 850) begin
            write_config(random_cfg());
            random_frames(2);
            drain();
        end

        c = random_cfg();
        c.max_meta = 32'd40;
        c.max_body = 32'd20;
        write_config(c);
        make_frame(0, 0, 0);
        cause = $urandom_range(2);
        if (cause == 0) frame_bytes[1] = frame_bytes[1] ^ 8'h01;
        else if (cause == 1) frame_bytes[2] = frame_bytes[2] ^ 8'h80;
        else frame_bytes[23] = 8'd21;
        send_frame();
        repeat (30) send_byte(8'($urandom));
        drain();

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("rpc_frame_tlv_deframer regression: pass");
        end else begin
            $display("rpc_frame_tlv_deframer regression: fail");
        end
        $finish;
    end

endmodule
